FILE: hdl/afcf_pkg.sv
// Shared types, constants and coefficient table of the ADC channel FIR clamp filter.
`timescale 1ns / 1ps

package afcf_pkg;

  // Lane layout of one frame.
  localparam int unsigned Lanes       = 4;
  localparam int unsigned WordWidth   = 16;
  localparam int unsigned MaxChannels = 4;

  // Sample path widths.
  localparam int unsigned CodeWidth   = 14;  // ADC code bits kept from each word
  localparam int unsigned SampleWidth = 15;  // signed sample after offset removal
  localparam int unsigned AccWidth    = 21;  // quarter-unit filter sum
  localparam int unsigned CoefWidth   = 5;   // quarter-unit coefficient
  localparam int unsigned CoefCount   = 9;   // taps with a coefficient slot in the table

  localparam logic [WordWidth-1:0] TopBits = 16'hC000;

  // Configuration register widths and reset values.
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 14;
  localparam int unsigned CountWidth    = 3;
  localparam int unsigned LaneSelWidth  = 2;

  localparam logic [CountWidth-1:0] ChannelCountReset = 3'd4;
  localparam logic [CodeWidth-1:0]  CenterReset       = 14'd8191;
  localparam logic [CodeWidth-1:0]  ClampReset        = 14'd8191;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_CHANNEL_COUNT  = 3'd0,
    REG_FILTER_CHANNEL = 3'd1,
    REG_RESULT_CHANNEL = 3'd2,
    REG_CENTER_OFFSET  = 3'd3,
    REG_CLAMP_LIMIT    = 3'd4
  } cfg_reg_t;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [AccWidth-1:0]    acc_t;

  // Coefficients held times four; taps past the table contribute nothing.
  function automatic logic signed [CoefWidth-1:0] quarter_coef(input int unsigned k);
    logic signed [CoefWidth-1:0] c;
    case (k)
      0:       c = -5'sd3;
      1:       c = 5'sd5;
      2:       c = 5'sd3;
      3:       c = -5'sd9;
      4:       c = 5'sd0;
      5:       c = 5'sd9;
      6:       c = -5'sd3;
      7:       c = -5'sd5;
      8:       c = 5'sd3;
      default: c = 5'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/adc_channel_fir_clamp_filter.sv
// Top level of the ADC channel FIR clamp filter: lane select, FIR, clamp and lane replace.
`timescale 1ns / 1ps

// One frame of four 16-bit ADC words enters per transaction on the s_ side and one
// frame leaves per transaction on the m_ side. The block takes a new frame in every
// clock cycle unless the m_ side stalls, and each accepted frame passes through
// the two-stage pipeline (filter sum register, then output register); a stall on
// the m_ side holds both stages and drops s_tready only once both are full. The
// word of lane filter_channel is masked to 14 bits, center_offset is subtracted, and
// the sample runs through a fixed 9-tap FIR with quarter-step coefficients (-0.75,
// 1.25, 0.75, -2.25, 0, 2.25, -0.75, -1.25, 0.75) computed exactly in quarter units.
// The sum is clamped to +/- clamp_limit, center_offset is added back, the value is
// truncated toward zero and 0xC000 is ORed in. That word replaces lane result_channel
// when that lane is below channel_count (capped at four); all other words pass
// unchanged. The delay line advances by one sample on every accepted frame and is
// cleared by reset. Configuration writes take effect at once and should only be made
// while no frame is in flight.
module adc_channel_fir_clamp_filter
  import afcf_pkg::*;
#(
  parameter int unsigned TAPS = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input frames
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [Lanes*WordWidth-1:0] s_tdata,  // sample_0 [15:0], sample_1 [31:16],
                                               // sample_2 [47:32], sample_3 [63:48]
  // Output frames
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [Lanes*WordWidth-1:0] m_tdata,  // out_0 [15:0], out_1 [31:16],
                                               // out_2 [47:32], out_3 [63:48]
  // Configuration writes
  input  logic                     cfg_wr_en,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_wr_data
);

  // Only the first CoefCount taps carry a coefficient, so the delay line stops there.
  localparam int unsigned TapsUsed  = (TAPS < CoefCount) ? TAPS : CoefCount;
  localparam int unsigned HistDepth = TapsUsed - 1;
  localparam int unsigned HistStore = (HistDepth > 0) ? HistDepth : 1;

  // Configuration registers.
  logic [CountWidth-1:0]   channel_count;
  logic [LaneSelWidth-1:0] filter_channel;
  logic [LaneSelWidth-1:0] result_channel;
  logic [CodeWidth-1:0]    center_offset;
  logic [CodeWidth-1:0]    clamp_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count  <= ChannelCountReset;
      filter_channel <= '0;
      result_channel <= '0;
      center_offset  <= CenterReset;
      clamp_limit    <= ClampReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CHANNEL_COUNT:  channel_count  <= cfg_wr_data[CountWidth-1:0];
        REG_FILTER_CHANNEL: filter_channel <= cfg_wr_data[LaneSelWidth-1:0];
        REG_RESULT_CHANNEL: result_channel <= cfg_wr_data[LaneSelWidth-1:0];
        REG_CENTER_OFFSET:  center_offset  <= cfg_wr_data[CodeWidth-1:0];
        REG_CLAMP_LIMIT:    clamp_limit    <= cfg_wr_data[CodeWidth-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: the output register moves when empty or taken, the sum
  // register moves when empty or when it can hand over to the output register.
  logic s1_valid;
  logic out_adv;
  logic s1_adv;
  logic s_accept;

  assign out_adv  = !m_tvalid || m_tready;
  assign s1_adv   = !s1_valid || out_adv;
  assign s_tready = s1_adv;
  assign s_accept = s_tvalid && s_tready;

  // Stage 1: lane select, offset removal and filter sum.
  logic [WordWidth-1:0] sel_word;
  sample_t              x_in;
  acc_t                 acc_next;
  sample_t              hist [HistStore];

  assign sel_word = s_tdata[filter_channel*WordWidth +: WordWidth];
  assign x_in = sample_t'({1'b0, sel_word[CodeWidth-1:0]}) - sample_t'({1'b0, center_offset});

  always_comb begin
    acc_next = acc_t'(x_in) * acc_t'(quarter_coef(0));
    for (int unsigned k = 1; k < TapsUsed; k++) begin
      acc_next = acc_next + acc_t'(hist[k-1]) * acc_t'(quarter_coef(k));
    end
  end

  // Delay line: entry 0 holds the most recent past sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int unsigned k = 0; k < HistStore; k++) begin
        hist[k] <= '0;
      end
    end else if (s_accept && (HistDepth > 0)) begin
      hist[0] <= x_in;
      for (int unsigned k = 1; k < HistStore; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  acc_t                       s1_acc;
  logic [Lanes*WordWidth-1:0] s1_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= s_tvalid;
    end
    if (s_accept) begin
      s1_acc <= acc_next;
      s1_raw <= s_tdata;
    end
  end

  // Stage 2: clamp, restore offset, truncate toward zero, replace the result lane.
  acc_t                        lim4;
  acc_t                        acc_clamped;
  logic signed [17:0]          v4;
  logic signed [17:0]          v4_biased;
  logic signed [17:0]          quot;
  logic [WordWidth-1:0]        filt_word;
  logic [CountWidth-1:0]       lanes_valid;
  logic [Lanes-1:0]            repl_next;
  logic [Lanes*WordWidth-1:0]  out_next;
  logic [Lanes-1:0]            repl_mask;

  always_comb begin
    lim4 = acc_t'({clamp_limit, 2'b00});
    if (s1_acc > lim4) begin
      acc_clamped = lim4;
    end else if (s1_acc < -lim4) begin
      acc_clamped = -lim4;
    end else begin
      acc_clamped = s1_acc;
    end
    v4 = acc_clamped[17:0] + $signed({2'b00, center_offset, 2'b00});
    // Arithmetic shift floors, so negative values get a bias of three first.
    v4_biased = v4[17] ? (v4 + 18'sd3) : v4;
    quot = v4_biased >>> 2;
    filt_word = quot[WordWidth-1:0] | TopBits;

    lanes_valid = (channel_count > CountWidth'(MaxChannels)) ?
                  CountWidth'(MaxChannels) : channel_count;
    for (int unsigned k = 0; k < Lanes; k++) begin
      repl_next[k] = (CountWidth'(k) < lanes_valid) &&
                     (LaneSelWidth'(k) == result_channel);
      out_next[k*WordWidth +: WordWidth] = repl_next[k] ?
                                           filt_word : s1_raw[k*WordWidth +: WordWidth];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s1_valid;
    end
    if (out_adv && s1_valid) begin
      m_tdata   <= out_next;
      repl_mask <= repl_next;
    end
  end

`ifndef SYNTHESIS
  // Input back-pressure only when both pipeline stages are full and the output stalls.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("s_tready low without a full, stalled pipeline");

  // Reset leaves the first and last delay line entries cleared.
  assert property (@(posedge clk)
    rst |=> (hist[0] == '0) && (hist[HistStore-1] == '0))
    else $error("delay line not cleared by reset");

  // Every accepted frame pushes its sample into the head of the delay line.
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && (HistDepth > 0)) |=> (hist[0] == $past(x_in)))
    else $error("delay line did not take the accepted sample");

  // At most one lane is replaced, and a replaced word carries the top marker bits.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(repl_mask) &&
      (!repl_mask[0] || (m_tdata[15:14] == 2'b11)) &&
      (!repl_mask[1] || (m_tdata[31:30] == 2'b11)) &&
      (!repl_mask[2] || (m_tdata[47:46] == 2'b11)) &&
      (!repl_mask[3] || (m_tdata[63:62] == 2'b11)))
    else $error("replaced lane word malformed");

  // A frame in the sum register reaches the output once the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_adv) |=> m_tvalid)
    else $error("frame lost between pipeline stages");
`endif

endmodule
